// File: sv/instruction_record_serializer_macros.svh
// Assertion macros for the instruction record serializer.
// Taken in by the top level; no other dependencies.
`ifndef INSTRUCTION_RECORD_SERIALIZER_MACROS_SVH
`define INSTRUCTION_RECORD_SERIALIZER_MACROS_SVH

`ifndef SYNTH
// Plain invariant, checked every cycle outside reset.
`define IRS_ASSERT(lbl, clk_s, rst_ns, expr) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_ns) (expr)) \
		else $error("assertion failed");
// Antecedent implies consequent in the next cycle.
`define IRS_ASSERT_NEXT(lbl, clk_s, rst_ns, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_ns) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define IRS_ASSERT(lbl, clk_s, rst_ns, expr)
`define IRS_ASSERT_NEXT(lbl, clk_s, rst_ns, ante, cons)
`endif

`endif

// File: sv/irs_pkg.sv
// Shared types, constants and tables of the instruction record serializer.
// No dependencies.
`timescale 1ns / 1ps

package irs_pkg;

	// Operand index width; indices are kept modulo 2^INDEX_BITS within the 31-bit field.
	localparam int INDEX_BITS = 31;
	localparam int FIELD_W    = 31;
	localparam int IDX_W      = (INDEX_BITS < FIELD_W) ? INDEX_BITS : FIELD_W;
	localparam logic [FIELD_W-1:0] IDX_MASK = FIELD_W'((64'h1 << IDX_W) - 64'h1);

	localparam int IN_W   = 176;
	localparam int USER_W = 1;
	localparam int BYTE_W = 8;

	// Queue between front and back.
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef enum logic {
		OP_BEGIN = 1'b0,
		OP_INSTR = 1'b1
	} op_t;

	// Presence mask bit positions
	localparam int MB_A     = 0;
	localparam int MB_B     = 1;
	localparam int MB_C     = 2;
	localparam int MB_ANGLE = 3;

	// One classified request. For a begin request value holds the count and mask is zero;
	// for an instruction it holds the angle bits.
	typedef struct packed {
		op_t                op;
		logic [31:0]        value;
		logic [7:0]         opcode;
		logic [3:0]         mask;
		logic [FIELD_W-1:0] idx_a;
		logic [FIELD_W-1:0] idx_b;
		logic [FIELD_W-1:0] idx_c;
	} job_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	typedef enum logic [5:0] {
		PH_TAG  = 6'b000001,
		PH_OPC  = 6'b000010,
		PH_MASK = 6'b000100,
		PH_VAR  = 6'b001000,
		PH_ZERO = 6'b010000,
		PH_ANG  = 6'b100000
	} phase_t;

	// Section tag "INST"
	function automatic logic [7:0] tag_byte(input logic [1:0] k);
		logic [7:0] b;
		case (k)
			2'd0:    b = 8'h49;
			2'd1:    b = 8'h4E;
			2'd2:    b = 8'h53;
			2'd3:    b = 8'h54;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// File: sv/irs_front.sv
// Front end: accepts input requests, unpacks and classifies them into jobs.
// Depends on irs_pkg.
`timescale 1ns / 1ps

module irs_front import irs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,
	input  logic [USER_W-1:0] s_tuser,
	output logic              push,
	output job_t              job,
	input  q_status_t         q_status
);

	logic valid_s1;
	job_t job_s1;
	job_t job_d;
	logic is_instr;

	assign push     = valid_s1 & ~q_status.full;
	assign s_tready = ~valid_s1 | ~q_status.full;
	assign job      = job_s1;
	assign is_instr = (s_tuser[0] == OP_INSTR);

	always_comb begin
		job_d        = '0;
		job_d.opcode = s_tdata[39:32];
		job_d.idx_a  = s_tdata[71:41] & IDX_MASK;
		job_d.idx_b  = s_tdata[103:73] & IDX_MASK;
		job_d.idx_c  = s_tdata[135:105] & IDX_MASK;
		if (is_instr) begin
			job_d.op    = OP_INSTR;
			job_d.value = s_tdata[168:137];
			job_d.mask  = {s_tdata[136], s_tdata[104], s_tdata[72], s_tdata[40]};
		end else begin
			job_d.op    = OP_BEGIN;
			job_d.value = s_tdata[31:0];
			job_d.mask  = 4'b0000;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			job_s1 <= job_d;
		end
	end

endmodule

// File: sv/irs_queue.sv
// Short job queue between the front and back ends.
// Depends on irs_pkg.
`timescale 1ns / 1ps

module irs_queue import irs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  job_t      wr_job,
	input  logic      pop,
	output job_t      rd_job,
	output q_status_t status
);

	job_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;

	assign status.empty = (cnt_q == '0);
	assign status.full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign rd_job       = mem_q[rd_ptr_q];

	function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
		return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

// File: sv/irs_back.sv
// Back end: walks one job at a time and emits its bytes, one per cycle unless the output stalls, into
// the output register. Depends on irs_pkg.
`timescale 1ns / 1ps

module irs_back import irs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	input  job_t              job,
	output logic              pop,
	output logic              busy,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [BYTE_W-1:0] m_tdata,
	output logic              m_tlast
);

	logic        busy_q;
	phase_t      phase_q, phase_n;
	logic [1:0]  cnt_q, cnt_n;
	logic [31:0] vsr_q, vsr_n;
	logic [2:0]  pend_q, pend_n;
	job_t        job_q;

	logic        out_ready, step, fin, advance, more;
	logic [7:0]  byte_d;
	logic [7:0]  out_byte_q;
	logic        out_last_q, out_valid_q;

	assign out_ready = ~out_valid_q | m_tready;
	assign step      = busy_q & out_ready;
	assign pop       = job_valid & (~busy_q | (step & fin));
	assign busy      = busy_q;
	assign more      = |vsr_q[31:7];

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;

	always_comb begin
		phase_n = phase_q;
		cnt_n   = cnt_q;
		vsr_n   = vsr_q;
		pend_n  = pend_q;
		byte_d  = 8'h00;
		fin     = 1'b0;
		advance = 1'b0;
		case (phase_q)
			PH_TAG: begin
				byte_d = tag_byte(cnt_q);
				if (cnt_q == 2'd3) phase_n = PH_VAR;
				else               cnt_n   = cnt_q + 2'd1;
			end
			PH_OPC: begin
				byte_d  = job_q.opcode;
				phase_n = PH_MASK;
			end
			PH_MASK: begin
				byte_d  = {4'b0000, job_q.mask};
				advance = 1'b1;
			end
			PH_VAR: begin
				// ULEB128 group: low 7 bits, bit 7 set while more groups follow
				byte_d  = {more, vsr_q[6:0]};
				vsr_n   = {7'b0, vsr_q[31:7]};
				advance = ~more;
			end
			PH_ZERO: begin
				byte_d  = 8'h00;
				phase_n = PH_ANG;
				cnt_n   = 2'd0;
			end
			PH_ANG: begin
				byte_d = job_q.value[{cnt_q, 3'b000} +: 8];
				if (cnt_q == 2'd3) fin   = 1'b1;
				else               cnt_n = cnt_q + 2'd1;
			end
			default: begin
				fin = 1'b1;
			end
		endcase
		// Pick the next field after the mask or a finished varint
		if (advance) begin
			if (pend_q[MB_A]) begin
				phase_n      = PH_VAR;
				vsr_n        = {1'b0, job_q.idx_a};
				pend_n[MB_A] = 1'b0;
			end else if (pend_q[MB_B]) begin
				phase_n      = PH_VAR;
				vsr_n        = {1'b0, job_q.idx_b};
				pend_n[MB_B] = 1'b0;
			end else if (pend_q[MB_C]) begin
				phase_n      = PH_VAR;
				vsr_n        = {1'b0, job_q.idx_c};
				pend_n[MB_C] = 1'b0;
			end else if (job_q.mask[MB_ANGLE]) begin
				phase_n = PH_ZERO;
			end else begin
				fin = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			phase_q     <= PH_TAG;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q  <= 1'b1;
				phase_q <= (job.op == OP_BEGIN) ? PH_TAG : PH_OPC;
			end else if (step) begin
				if (fin) busy_q <= 1'b0;
				phase_q <= phase_n;
			end
			if (out_ready) out_valid_q <= step;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q  <= job;
			cnt_q  <= 2'd0;
			vsr_q  <= job.value;
			pend_q <= job.mask[2:0];
		end else if (step) begin
			cnt_q  <= cnt_n;
			vsr_q  <= vsr_n;
			pend_q <= pend_n;
		end
		if (step) begin
			out_byte_q <= byte_d;
			out_last_q <= fin;
		end
	end

endmodule

// File: sv/instruction_record_serializer.sv
// Channel | dir | tdata (low bit up)                               | tuser / tlast
// s_*     | in  | section_count, opcode, has_a, index_a, has_b,    | tuser: operation
//         |     | index_b, has_c, index_c, has_angle, angle_bits   |
// m_*     | out | out_byte                                         | tlast: last_byte
//
// One output byte per cycle from the back end unless m_tready stalls it. An item has
// 5 to 9 bytes for a begin request, 2 to 22 for an instruction. The back end's byte sequencer
// sets the rate; a waiting job is loaded in the cycle its predecessor's last byte is registered.
// The first byte passes the front register, queue, back-end job register and output register.
// Async reset clears control only. The front keeps taking requests while the two-entry
// queue has room, independent of m_tready.
`timescale 1ns / 1ps
`include "instruction_record_serializer_macros.svh"

module instruction_record_serializer import irs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// section_count[31:0], opcode[39:32], has_a[40], index_a[71:41], has_b[72],
	// index_b[103:73], has_c[104], index_c[135:105], has_angle[136], angle_bits[168:137]
	input  logic [IN_W-1:0]   s_tdata,
	// operation[0]
	input  logic [USER_W-1:0] s_tuser,
	output logic              m_tvalid,
	input  logic              m_tready,
	// out_byte[7:0]
	output logic [BYTE_W-1:0] m_tdata,
	output logic              m_tlast
);

	logic      push, pop, back_busy;
	job_t      fe_job, q_job;
	q_status_t q_status;

	irs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.push     (push),
		.job      (fe_job),
		.q_status (q_status)
	);

	irs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (fe_job),
		.pop    (pop),
		.rd_job (q_job),
		.status (q_status)
	);

	irs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (~q_status.empty),
		.job       (q_job),
		.pop       (pop),
		.busy      (back_busy),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	`IRS_ASSERT(a_no_push_full, clk, arst_n, !(push && q_status.full))
	`IRS_ASSERT(a_no_pop_empty, clk, arst_n, !(pop && q_status.empty))
	`IRS_ASSERT_NEXT(a_pop_busy, clk, arst_n, pop, back_busy)
	`IRS_ASSERT_NEXT(a_idle_quiet, clk, arst_n, !back_busy && !m_tvalid, !m_tvalid)

endmodule

// File: verif/instruction_record_serializer_test.sv
// Self-checking bench for instruction_record_serializer: drives section and instruction
// requests on the input stream and checks every output byte and its tlast flag.
// Depends on irs_pkg and the serializer RTL only.
`timescale 1ns / 1ps

module instruction_record_serializer_test;
	import irs_pkg::*;

	localparam int IDLE_LIMIT  = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam int KEEP_W      = (INDEX_BITS < FIELD_W) ? INDEX_BITS : FIELD_W;
	localparam logic [FIELD_W-1:0] KEEP_MASK = {FIELD_W{1'b1}} >> (FIELD_W - KEEP_W);
	localparam logic [31:0] SECTION_TAG = "INST";
	localparam logic [7:0]  ULEB_LOW    = 8'h7F;
	localparam logic [7:0]  ULEB_MORE   = 8'h80;
	localparam logic [7:0]  ANGLE_TAG   = 8'h00;
	localparam logic [3:0]  HAS_A       = 4'(1 << MB_A);
	localparam logic [3:0]  HAS_B       = 4'(1 << MB_B);
	localparam logic [3:0]  HAS_C       = 4'(1 << MB_C);
	localparam logic [3:0]  HAS_ANGLE   = 4'(1 << MB_ANGLE);
	localparam logic [3:0]  HAS_ALL     = HAS_A | HAS_B | HAS_C | HAS_ANGLE;

	typedef struct {
		op_t                op;
		logic [31:0]        count;
		logic [7:0]         opcode;
		logic [3:0]         present;
		logic [FIELD_W-1:0] index_a;
		logic [FIELD_W-1:0] index_b;
		logic [FIELD_W-1:0] index_c;
		logic [31:0]        angle;
	} record_t;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} stream_byte_t;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	// section_count, opcode, has_a, index_a, has_b, index_b, has_c, index_c, has_angle,
	// angle_bits
	logic [IN_W-1:0]   s_tdata  = '0;
	// operation
	logic [USER_W-1:0] s_tuser  = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	// out_byte
	logic [BYTE_W-1:0] m_tdata;
	logic              m_tlast;

	record_t      pending[$];
	stream_byte_t expected_bytes[$];
	int           accepted_in;
	int           mismatches;
	int           hold_left;
	int           holds_done;

	instruction_record_serializer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [IN_W-1:0] pack_record(record_t r);
		return IN_W'({r.angle, r.present[MB_ANGLE], r.index_c, r.present[MB_C],
			r.index_b, r.present[MB_B], r.index_a, r.present[MB_A], r.opcode, r.count});
	endfunction

	function automatic void append_uleb(ref logic [7:0] seq[$], input logic [63:0] v);
		logic [63:0] rest;
		logic [7:0]  b;
		rest = v;
		do begin
			b = rest[7:0] & ULEB_LOW;
			rest = rest >> 7;
			if (rest != 0)
				b = b | ULEB_MORE;
			seq.insert(seq.size(), b);
		end while (rest != 0);
	endfunction

	// Expected byte run of one request, appended to expected_bytes.
	function automatic void serialize_record(record_t r);
		logic [7:0]   seq[$];
		stream_byte_t e;
		if (r.op == OP_BEGIN) begin
			for (int k = 3; k >= 0; k--)
				seq.insert(seq.size(), SECTION_TAG[8*k +: 8]);
			append_uleb(seq, 64'(r.count));
		end else begin
			seq.insert(seq.size(), r.opcode);
			seq.insert(seq.size(), {4'b0, r.present});
			if (r.present[MB_A])
				append_uleb(seq, 64'(r.index_a & KEEP_MASK));
			if (r.present[MB_B])
				append_uleb(seq, 64'(r.index_b & KEEP_MASK));
			if (r.present[MB_C])
				append_uleb(seq, 64'(r.index_c & KEEP_MASK));
			if (r.present[MB_ANGLE]) begin
				seq.insert(seq.size(), ANGLE_TAG);
				for (int k = 0; k < 4; k++)
					seq.insert(seq.size(), r.angle[8*k +: 8]);
			end
		end
		foreach (seq[i]) begin
			e.data = seq[i];
			e.last = (i == seq.size() - 1);
			expected_bytes.insert(expected_bytes.size(), e);
		end
	endfunction

	function automatic void queue_item(record_t r);
		pending.insert(pending.size(), r);
	endfunction

	// Spread over varint lengths: short values, truncated widths, full words.
	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 3))
			0:       return 32'($urandom_range(0, 127));
			1:       return $urandom >> $urandom_range(1, 28);
			default: return $urandom;
		endcase
	endfunction

	// Unused fields get random junk so that ignoring them is exercised.
	function automatic record_t make_begin(logic [31:0] count);
		record_t r;
		r.op      = OP_BEGIN;
		r.count   = count;
		r.opcode  = 8'($urandom);
		r.present = 4'($urandom);
		r.index_a = FIELD_W'($urandom);
		r.index_b = FIELD_W'($urandom);
		r.index_c = FIELD_W'($urandom);
		r.angle   = $urandom;
		return r;
	endfunction

	function automatic record_t make_instr(logic [7:0] opcode, logic [3:0] present,
			logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b, logic [FIELD_W-1:0] c,
			logic [31:0] angle);
		record_t r;
		r.op      = OP_INSTR;
		r.count   = $urandom;
		r.opcode  = opcode;
		r.present = present;
		r.index_a = a;
		r.index_b = b;
		r.index_c = c;
		r.angle   = angle;
		return r;
	endfunction

	function automatic record_t random_instr();
		return make_instr(8'($urandom), 4'($urandom), FIELD_W'(rand_value()),
			FIELD_W'(rand_value()), FIELD_W'(rand_value()), $urandom);
	endfunction

	// Per-request wait, with occasional runs of zero wait.
	function automatic int draw_wait(inout bit calm);
		if ($urandom_range(0, 24) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, 13);
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch after %0d requests: %s", accepted_in, msg);
		mismatches++;
	endtask

	// Long output stall, twice, so the front end fills and backs up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left  <= 0;
			holds_done <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if ((holds_done == 0 && accepted_in >= 60) ||
				(holds_done == 1 && accepted_in >= 150)) begin
			hold_left  <= HOLD_CYCLES;
			holds_done <= holds_done + 1;
		end
	end

	record_t cur_record;
	int      gap_left;
	bit      tx_calm;

	always @(posedge clk or negedge arst_n) begin : driver
		logic nxt_valid;
		if (!arst_n) begin
			s_tvalid    <= 1'b0;
			accepted_in <= 0;
			gap_left = 0;
		end else begin
			nxt_valid = s_tvalid;
			if (s_tvalid && s_tready) begin
				serialize_record(cur_record);
				accepted_in <= accepted_in + 1;
				nxt_valid = 1'b0;
			end
			if (!nxt_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending.size() != 0) begin
					cur_record = pending.pop_front();
					s_tdata <= pack_record(cur_record);
					s_tuser <= USER_W'(cur_record.op);
					nxt_valid = 1'b1;
					gap_left = (hold_left != 0) ? 0 : draw_wait(tx_calm);
				end
			end
			s_tvalid <= nxt_valid;
		end
	end

	stream_byte_t want;
	int           wait_left;
	bit           rx_calm;

	always @(posedge clk or negedge arst_n) begin : monitor
		if (!arst_n) begin
			m_tready <= 1'b0;
			wait_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_bytes.size() == 0) begin
					report_mismatch($sformatf("unexpected byte %h last %b", m_tdata, m_tlast));
				end else begin
					want = expected_bytes.pop_front();
					if (m_tdata !== want.data)
						report_mismatch($sformatf("byte %h, want %h", m_tdata, want.data));
					if (m_tlast !== want.last)
						report_mismatch($sformatf("tlast %b, want %b", m_tlast, want.last));
				end
				wait_left = draw_wait(rx_calm);
			end else if (wait_left > 0) begin
				wait_left--;
			end
			m_tready <= (hold_left == 0) && (wait_left == 0);
		end
	end

	initial begin : stimulus
		int sent;
		int n;
		int total;
		// count varints of one, two, four and five bytes at their boundaries
		queue_item(make_begin(32'd0));
		queue_item(make_begin(32'd127));
		queue_item(make_begin(32'd128));
		queue_item(make_begin(32'd16383));
		queue_item(make_begin(32'h0FFF_FFFF));
		queue_item(make_begin(32'h1000_0000));
		queue_item(make_begin(32'hFFFF_FFFF));
		// bare record, then the longest one
		queue_item(make_instr(8'h00, 4'b0, FIELD_W'($urandom), FIELD_W'($urandom),
			FIELD_W'($urandom), $urandom));
		queue_item(make_instr(8'hFF, HAS_ALL, {FIELD_W{1'b1}}, {FIELD_W{1'b1}},
			{FIELD_W{1'b1}}, 32'hFFFF_FFFF));
		queue_item(make_instr(8'h5A, HAS_ALL, '0, '0, '0, 32'h0));
		queue_item(make_instr(8'h01, HAS_A, FIELD_W'(127), FIELD_W'($urandom),
			FIELD_W'($urandom), $urandom));
		queue_item(make_instr(8'h02, HAS_B, FIELD_W'($urandom), FIELD_W'(128),
			FIELD_W'($urandom), $urandom));
		queue_item(make_instr(8'h03, HAS_C, FIELD_W'($urandom), FIELD_W'($urandom),
			FIELD_W'(16384), $urandom));
		queue_item(make_instr(8'h80, HAS_ANGLE, FIELD_W'($urandom), FIELD_W'($urandom),
			FIELD_W'($urandom), 32'h3F80_0000));
		queue_item(make_instr(8'h7F, HAS_A | HAS_C, FIELD_W'(32'h1000_0000),
			FIELD_W'($urandom), FIELD_W'(32'h0FFF_FFFF), $urandom));
		queue_item(make_instr(8'hC3, HAS_B | HAS_ANGLE, FIELD_W'($urandom),
			FIELD_W'(16383), FIELD_W'($urandom), 32'h8000_0001));

		// mostly well-formed sections; some stray requests and cut-short sections
		sent = 0;
		while (sent < 180) begin
			if ($urandom_range(0, 3) == 0) begin
				queue_item($urandom_range(0, 1) ? make_begin(rand_value()) : random_instr());
				sent++;
			end else begin
				n = $urandom_range(1, 8);
				queue_item(make_begin(32'(n)));
				if ($urandom_range(0, 5) == 0)
					n = $urandom_range(0, n - 1);
				repeat (n) queue_item(random_instr());
				sent += n + 1;
			end
		end
		total = pending.size();

		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (accepted_in != total) @(posedge clk);
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle = 0;
			else
				idle++;
		end
		$display("stalled for %0d cycles", IDLE_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
